>>> hw/rtl/mac_group_membership_table_core_macros.svh
// Assertion macros used by the checker file of the group membership table.
// No dependencies; a file takes these in by include.
`ifndef MAC_GROUP_MEMBERSHIP_TABLE_CORE_MACROS_SVH
`define MAC_GROUP_MEMBERSHIP_TABLE_CORE_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define MGT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clock and reset names.
`define MGT_ASSERT(label, prop, msg) \
  `MGT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/mgt_pkg.sv
// Types and constants of the MAC group membership table.
// No dependencies; used by the interfaces, controller, datapath, top level and checker.
`default_nettype none

package mgt_pkg;

  // Fixed field widths of the command and result items.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MCNT_W   = 5;

  // A list item gives at most this many results.
  localparam int unsigned RESULT_LIMIT = 16;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_GROUP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Command kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_FIND   = 3'd5,
    KIND_LIST   = 3'd6,
    KIND_CHECK  = 3'd7
  } kind_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GSCAN,
    S_LSTART,
    S_HREAD,
    S_HCMP,
    S_RM_RD,
    S_RM_WR,
    S_LMATCH,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic init;
    logic slot_hit;
    logic pos_inc;
    logic grp_load;
    logic hidx_inc;
    logic rd_host;
    logic rd_last;
    logic wr_moved;
    logic acc;
    logic mark_hit;
    logic grp_end;
    logic list_match;
    logic finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  pos_end;
    logic  gid_eq;
    logic  hidx_end;
    logic  eq_a;
    logic  pend;
    logic  k_full;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/mgt_stream_if.sv
// Valid/ready channel interfaces for command and result items.
// Depends on mgt_pkg for the field widths.
`default_nettype none

interface mgt_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [mgt_pkg::KIND_W-1:0]  kind;
  logic [mgt_pkg::ID_W-1:0]    target_id;
  logic [mgt_pkg::MAC_W-1:0]   mac_a;
  logic [mgt_pkg::MAC_W-1:0]   mac_b;

  modport source (output valid, kind, target_id, mac_a, mac_b, input ready);
  modport sink   (input valid, kind, target_id, mac_a, mac_b, output ready);
endinterface

interface mgt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mgt_pkg::STATUS_W-1:0] status;
  logic                         hit;
  logic [mgt_pkg::ID_W-1:0]     result_group_id;
  logic [mgt_pkg::MCNT_W-1:0]   match_count;
  logic                         last;

  modport source (output valid, status, hit, result_group_id, match_count, last,
                  input ready);
  modport sink   (input valid, status, hit, result_group_id, match_count, last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mac_group_membership_table_core.sv
// Create takes a free slot with no search; delete, add, clear, find and remove first
// search the groups newest-first. Find and remove then read the group's MAC entries,
// and remove moves the last entry onto the match. List and check scan the groups;
// a list goes to the next group after a match and stops at RESULT_LIMIT matches.
// One item at a time; a held result stalls the final step and a list match. Async reset
// empties all groups and loads the next id with 0; the MAC store is not cleared.
`default_nettype none

module mac_group_membership_table_core #(
  parameter int unsigned MAX_GROUPS      = 16,
  parameter int unsigned HOSTS_PER_GROUP = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [mgt_pkg::ID_W-1:0] cfg_wdata_i,
  mgt_cmd_if.sink                       cmd_i,
  mgt_rsp_if.source                     rsp_o
);

  mgt_pkg::ctl_t ctl;
  mgt_pkg::sts_t sts;
  logic          cmd_ready;

  // Sequencer.
  mgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  assign cmd_i.ready = cmd_ready;

  // Tables, MAC store and result register.
  mgt_dp #(
    .MAX_GROUPS      (MAX_GROUPS),
    .HOSTS_PER_GROUP (HOSTS_PER_GROUP)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (cmd_i.kind),
    .target_id_i       (cmd_i.target_id),
    .mac_a_i           (cmd_i.mac_a),
    .mac_b_i           (cmd_i.mac_b),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_status_o      (rsp_o.status),
    .rsp_hit_o         (rsp_o.hit),
    .rsp_group_id_o    (rsp_o.result_group_id),
    .rsp_match_count_o (rsp_o.match_count),
    .rsp_last_o        (rsp_o.last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mgt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mgt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/mgt_ctrl.sv
// Controller state machine of the group membership table.
// Depends on mgt_pkg; drives the datapath through ctl_t and reads sts_t.
`default_nettype none

module mgt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire mgt_pkg::sts_t sts_i,
  output mgt_pkg::ctl_t      ctl_o
);

  mgt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mgt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mgt_pkg::S_IDLE: begin
        if (cmd_valid_i) state_d = mgt_pkg::S_DECODE;
      end
      mgt_pkg::S_DECODE: begin
        case (sts_i.kind)
          mgt_pkg::KIND_CREATE: state_d = mgt_pkg::S_DONE;
          mgt_pkg::KIND_LIST, mgt_pkg::KIND_CHECK: state_d = mgt_pkg::S_LSTART;
          default: state_d = mgt_pkg::S_GSCAN;
        endcase
      end
      mgt_pkg::S_GSCAN: begin
        if (sts_i.pos_end) begin
          state_d = mgt_pkg::S_DONE;
        end else if (sts_i.gid_eq) begin
          if (sts_i.kind inside {mgt_pkg::KIND_REMOVE, mgt_pkg::KIND_FIND}) begin
            state_d = mgt_pkg::S_HREAD;
          end else begin
            state_d = mgt_pkg::S_DONE;
          end
        end
      end
      mgt_pkg::S_LSTART: begin
        state_d = sts_i.pos_end ? mgt_pkg::S_DONE : mgt_pkg::S_HREAD;
      end
      mgt_pkg::S_HREAD: begin
        if (sts_i.hidx_end) begin
          if (sts_i.kind inside {mgt_pkg::KIND_LIST, mgt_pkg::KIND_CHECK}) begin
            state_d = mgt_pkg::S_LSTART;
          end else begin
            state_d = mgt_pkg::S_DONE;
          end
        end else begin
          state_d = mgt_pkg::S_HCMP;
        end
      end
      mgt_pkg::S_HCMP: begin
        state_d = mgt_pkg::S_HREAD;
        if (sts_i.eq_a) begin
          case (sts_i.kind)
            mgt_pkg::KIND_FIND:   state_d = mgt_pkg::S_DONE;
            mgt_pkg::KIND_REMOVE: state_d = mgt_pkg::S_RM_RD;
            mgt_pkg::KIND_LIST:   state_d = mgt_pkg::S_LMATCH;
            default:              state_d = mgt_pkg::S_HREAD;
          endcase
        end
      end
      mgt_pkg::S_RM_RD: state_d = mgt_pkg::S_RM_WR;
      mgt_pkg::S_RM_WR: state_d = mgt_pkg::S_DONE;
      mgt_pkg::S_LMATCH: begin
        if (!sts_i.pend || sts_i.out_free) begin
          state_d = sts_i.k_full ? mgt_pkg::S_DONE : mgt_pkg::S_LSTART;
        end
      end
      mgt_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = mgt_pkg::S_IDLE;
      end
      default: state_d = mgt_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl_o       = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      mgt_pkg::S_IDLE: begin
        cmd_ready_o   = 1'b1;
        ctl_o.capture = cmd_valid_i;
      end
      mgt_pkg::S_DECODE: ctl_o.init = 1'b1;
      mgt_pkg::S_GSCAN: begin
        if (!sts_i.pos_end) begin
          ctl_o.slot_hit = sts_i.gid_eq;
          ctl_o.pos_inc  = !sts_i.gid_eq;
        end
      end
      mgt_pkg::S_LSTART: ctl_o.grp_load = !sts_i.pos_end;
      mgt_pkg::S_HREAD: begin
        if (sts_i.hidx_end) begin
          if (sts_i.kind inside {mgt_pkg::KIND_LIST, mgt_pkg::KIND_CHECK}) begin
            ctl_o.pos_inc = 1'b1;
            ctl_o.grp_end = 1'b1;
          end
        end else begin
          ctl_o.rd_host = 1'b1;
        end
      end
      mgt_pkg::S_HCMP: begin
        if (sts_i.kind == mgt_pkg::KIND_CHECK) begin
          ctl_o.acc      = 1'b1;
          ctl_o.hidx_inc = 1'b1;
        end else if (sts_i.eq_a) begin
          ctl_o.mark_hit = (sts_i.kind == mgt_pkg::KIND_FIND);
        end else begin
          ctl_o.hidx_inc = 1'b1;
        end
      end
      mgt_pkg::S_RM_RD: ctl_o.rd_last  = 1'b1;
      mgt_pkg::S_RM_WR: ctl_o.wr_moved = 1'b1;
      mgt_pkg::S_LMATCH: begin
        if (!sts_i.pend || sts_i.out_free) begin
          ctl_o.list_match = 1'b1;
          ctl_o.pos_inc    = !sts_i.k_full;
        end
      end
      mgt_pkg::S_DONE: ctl_o.finish = sts_i.out_free;
      default: ctl_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/mgt_dp.sv
// Datapath of the group membership table: slot registers, group order list,
// MAC store, scan counters and the result register. Uses mgt_pkg and mgt_ram.
`default_nettype none

module mgt_dp #(
  parameter int unsigned MAX_GROUPS      = 16,
  parameter int unsigned HOSTS_PER_GROUP = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mgt_pkg::ID_W-1:0]     cfg_wdata_i,
  input  wire logic [mgt_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [mgt_pkg::ID_W-1:0]     target_id_i,
  input  wire logic [mgt_pkg::MAC_W-1:0]    mac_a_i,
  input  wire logic [mgt_pkg::MAC_W-1:0]    mac_b_i,
  input  wire mgt_pkg::ctl_t                ctl_i,
  output mgt_pkg::sts_t                     sts_o,
  input  wire logic                         rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [mgt_pkg::STATUS_W-1:0]      rsp_status_o,
  output logic                              rsp_hit_o,
  output logic [mgt_pkg::ID_W-1:0]          rsp_group_id_o,
  output logic [mgt_pkg::MCNT_W-1:0]        rsp_match_count_o,
  output logic                              rsp_last_o
);

  localparam int unsigned SLOT_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned CNT_W  = $clog2(HOSTS_PER_GROUP + 1);
  localparam int unsigned GCNT_W = $clog2(MAX_GROUPS + 1);
  localparam int unsigned DEPTH  = MAX_GROUPS * HOSTS_PER_GROUP;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] HPG_A  = ADDR_W'(HOSTS_PER_GROUP);
  localparam logic [CNT_W-1:0]  HPG_C  = CNT_W'(HOSTS_PER_GROUP);
  localparam logic [mgt_pkg::MCNT_W-1:0] K_LAST =
    mgt_pkg::MCNT_W'(mgt_pkg::RESULT_LIMIT - 1);

  // Captured command.
  mgt_pkg::kind_e                 kind_q, kind_d;
  logic [mgt_pkg::ID_W-1:0]       gid_q, gid_d;
  logic [mgt_pkg::MAC_W-1:0]      maca_q, maca_d, macb_q, macb_d;

  // Group table.
  logic                           used_q [MAX_GROUPS];
  logic                           used_d [MAX_GROUPS];
  logic [mgt_pkg::ID_W-1:0]       sgid_q [MAX_GROUPS];
  logic [mgt_pkg::ID_W-1:0]       sgid_d [MAX_GROUPS];
  logic [CNT_W-1:0]               scnt_q [MAX_GROUPS];
  logic [CNT_W-1:0]               scnt_d [MAX_GROUPS];
  logic [SLOT_W-1:0]              order_q [MAX_GROUPS];
  logic [SLOT_W-1:0]              order_d [MAX_GROUPS];
  logic [GCNT_W-1:0]              ngrp_q, ngrp_d;
  logic [mgt_pkg::ID_W-1:0]       next_id_q, next_id_d;

  // Scan state.
  logic [GCNT_W-1:0]              pos_q, pos_d;
  logic [SLOT_W-1:0]              slot_q, slot_d;
  logic [CNT_W-1:0]               hidx_q, hidx_d;
  logic [mgt_pkg::MCNT_W-1:0]     k_q, k_d;
  logic                           pend_q, pend_d;
  logic [mgt_pkg::ID_W-1:0]       pgid_q, pgid_d;
  logic                           gfound_q, gfound_d, hfound_q, hfound_d;
  logic                           ha_q, ha_d, hb_q, hb_d;
  logic                           anya_q, anya_d, anyb_q, anyb_d, both_q, both_d;

  // Result register.
  logic                           rvalid_q, rvalid_d;
  logic [mgt_pkg::STATUS_W-1:0]   rstat_q, rstat_d;
  logic                           rhit_q, rhit_d, rlast_q, rlast_d;
  logic [mgt_pkg::ID_W-1:0]       rgid_q, rgid_d;
  logic [mgt_pkg::MCNT_W-1:0]     rcnt_q, rcnt_d;

  // Derived values and memory port.
  logic [SLOT_W-1:0]              cur_slot, free_slot;
  logic                           free_any;
  logic [CNT_W-1:0]               cur_cnt;
  logic [ADDR_W-1:0]              base_addr;
  logic                           eq_a, eq_b, out_free;
  logic                           ram_we;
  logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
  logic [mgt_pkg::MAC_W-1:0]      ram_wdata, ram_rdata;

  assign cur_slot  = order_q[pos_q[SLOT_W-1:0]];
  assign cur_cnt   = scnt_q[slot_q];
  assign base_addr = ADDR_W'(slot_q) * HPG_A;
  assign eq_a      = (ram_rdata == maca_q);
  assign eq_b      = (ram_rdata == macb_q);
  assign out_free  = !rvalid_q || rsp_ready_i;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
      if (!used_q[i]) free_slot = SLOT_W'(i);
    end
    free_any = 1'b0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      free_any = free_any | !used_q[i];
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.kind     = kind_q;
    sts_o.pos_end  = (pos_q >= ngrp_q);
    sts_o.gid_eq   = used_q[cur_slot] && (sgid_q[cur_slot] == gid_q);
    sts_o.hidx_end = (hidx_q >= cur_cnt);
    sts_o.eq_a     = eq_a;
    sts_o.pend     = pend_q;
    sts_o.k_full   = (k_q == K_LAST);
    sts_o.out_free = out_free;
  end

  // Next values of all registers under the controller's commands.
  always_comb begin
    kind_d = kind_q; gid_d = gid_q; maca_d = maca_q; macb_d = macb_q;
    used_d = used_q; sgid_d = sgid_q; scnt_d = scnt_q; order_d = order_q;
    ngrp_d = ngrp_q; next_id_d = next_id_q;
    pos_d = pos_q; slot_d = slot_q; hidx_d = hidx_q; k_d = k_q;
    pend_d = pend_q; pgid_d = pgid_q; gfound_d = gfound_q; hfound_d = hfound_q;
    ha_d = ha_q; hb_d = hb_q; anya_d = anya_q; anyb_d = anyb_q; both_d = both_q;
    rvalid_d = rsp_ready_i ? 1'b0 : rvalid_q;
    rstat_d = rstat_q; rhit_d = rhit_q; rlast_d = rlast_q;
    rgid_d = rgid_q; rcnt_d = rcnt_q;
    ram_we    = 1'b0;
    ram_waddr = base_addr + ADDR_W'(hidx_q);
    ram_wdata = ram_rdata;
    ram_raddr = base_addr + ADDR_W'(hidx_q);

    if (cfg_we_i) next_id_d = cfg_wdata_i;

    if (ctl_i.capture) begin
      kind_d = mgt_pkg::kind_e'(kind_i);
      gid_d  = target_id_i;
      maca_d = mac_a_i;
      macb_d = mac_b_i;
    end
    if (ctl_i.init) begin
      pos_d = '0; k_d = '0; pend_d = 1'b0; gfound_d = 1'b0; hfound_d = 1'b0;
      ha_d = 1'b0; hb_d = 1'b0; anya_d = 1'b0; anyb_d = 1'b0; both_d = 1'b0;
    end
    if (ctl_i.slot_hit) begin
      slot_d = cur_slot; gfound_d = 1'b1; hidx_d = '0;
    end
    if (ctl_i.grp_load) begin
      slot_d = cur_slot; hidx_d = '0;
    end
    if (ctl_i.pos_inc)  pos_d  = pos_q + 1'b1;
    if (ctl_i.hidx_inc) hidx_d = hidx_q + 1'b1;
    if (ctl_i.acc) begin
      ha_d = ha_q | eq_a; hb_d = hb_q | eq_b;
    end
    if (ctl_i.mark_hit) hfound_d = 1'b1;
    if (ctl_i.grp_end) begin
      both_d = both_q | (ha_q & hb_q);
      anya_d = anya_q | ha_q;
      anyb_d = anyb_q | hb_q;
      ha_d = 1'b0; hb_d = 1'b0;
    end
    // Removal reads the last entry, then moves it onto the match.
    if (ctl_i.rd_last) ram_raddr = base_addr + ADDR_W'(cur_cnt - 1'b1);
    if (ctl_i.wr_moved) begin
      ram_we         = 1'b1;
      scnt_d[slot_q] = cur_cnt - 1'b1;
    end

    // A new list match: the held one goes out, not marked last.
    if (ctl_i.list_match) begin
      if (pend_q) begin
        rvalid_d = 1'b1; rstat_d = mgt_pkg::ST_OK; rhit_d = 1'b1;
        rgid_d = pgid_q; rcnt_d = k_q; rlast_d = 1'b0;
      end
      pgid_d = sgid_q[slot_q];
      pend_d = 1'b1;
      k_d    = k_q + 1'b1;
    end

    // Final result and table update.
    if (ctl_i.finish) begin
      rvalid_d = 1'b1; rstat_d = mgt_pkg::ST_OK; rhit_d = 1'b0;
      rgid_d = '0; rcnt_d = '0; rlast_d = 1'b1;
      if (!gfound_q && !(kind_q inside {mgt_pkg::KIND_CREATE, mgt_pkg::KIND_LIST,
                                         mgt_pkg::KIND_CHECK})) begin
        rstat_d = mgt_pkg::ST_NO_GROUP;
      end else begin
        case (kind_q)
          mgt_pkg::KIND_CREATE: begin
            if (free_any) begin
              used_d[free_slot] = 1'b1;
              sgid_d[free_slot] = next_id_q;
              scnt_d[free_slot] = '0;
              for (int i = 1; i < MAX_GROUPS; i++) order_d[i] = order_q[i-1];
              order_d[0] = free_slot;
              ngrp_d     = ngrp_q + 1'b1;
              next_id_d  = next_id_q + 1'b1;
              rgid_d     = next_id_q;
            end else begin
              rstat_d = mgt_pkg::ST_FULL;
            end
          end
          mgt_pkg::KIND_DELETE: begin
            used_d[slot_q] = 1'b0;
            scnt_d[slot_q] = '0;
            for (int i = 0; i + 1 < MAX_GROUPS; i++) begin
              if (GCNT_W'(i) >= pos_q) order_d[i] = order_q[i+1];
            end
            ngrp_d = ngrp_q - 1'b1;
          end
          mgt_pkg::KIND_ADD: begin
            if (cur_cnt >= HPG_C) begin
              rstat_d = mgt_pkg::ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = base_addr + ADDR_W'(cur_cnt);
              ram_wdata      = maca_q;
              scnt_d[slot_q] = cur_cnt + 1'b1;
            end
          end
          mgt_pkg::KIND_CLEAR: scnt_d[slot_q] = '0;
          mgt_pkg::KIND_FIND:  rhit_d = hfound_q;
          mgt_pkg::KIND_LIST: begin
            if (pend_q) begin
              rhit_d = 1'b1; rgid_d = pgid_q; rcnt_d = k_q;
            end
          end
          mgt_pkg::KIND_CHECK: rhit_d = both_q | !(anya_q | anyb_q);
          default: rhit_d = 1'b0;
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
        used_q[i] <= 1'b0;
        scnt_q[i] <= '0;
      end
      ngrp_q    <= '0;
      next_id_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      used_q    <= used_d;
      scnt_q    <= scnt_d;
      ngrp_q    <= ngrp_d;
      next_id_q <= next_id_d;
      rvalid_q  <= rvalid_d;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; gid_q <= gid_d; maca_q <= maca_d; macb_q <= macb_d;
    sgid_q <= sgid_d; order_q <= order_d;
    pos_q <= pos_d; slot_q <= slot_d; hidx_q <= hidx_d; k_q <= k_d;
    pend_q <= pend_d; pgid_q <= pgid_d; gfound_q <= gfound_d; hfound_q <= hfound_d;
    ha_q <= ha_d; hb_q <= hb_d; anya_q <= anya_d; anyb_q <= anyb_d; both_q <= both_d;
    rstat_q <= rstat_d; rhit_q <= rhit_d; rlast_q <= rlast_d;
    rgid_q <= rgid_d; rcnt_q <= rcnt_d;
  end

  // MAC store, one row of HOSTS_PER_GROUP entries per slot.
  mgt_ram #(
    .WIDTH (mgt_pkg::MAC_W),
    .DEPTH (DEPTH)
  ) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_valid_o       = rvalid_q;
  assign rsp_status_o      = rstat_q;
  assign rsp_hit_o         = rhit_q;
  assign rsp_group_id_o    = rgid_q;
  assign rsp_match_count_o = rcnt_q;
  assign rsp_last_o        = rlast_q;

endmodule

`default_nettype wire

>>> hw/rtl/mgt_checker.sv
// Port-level checks of the group membership table, bound to the top level.
// Depends on mgt_pkg and the assertion macros header.
`default_nettype none
`include "mac_group_membership_table_core_macros.svh"

module mgt_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cmd_valid_i,
  input wire logic                         cmd_ready_i,
  input wire logic                         rsp_valid_i,
  input wire logic                         rsp_ready_i,
  input wire logic [mgt_pkg::STATUS_W-1:0] rsp_status_i,
  input wire logic                         rsp_hit_i,
  input wire logic [mgt_pkg::MCNT_W-1:0]   rsp_match_count_i,
  input wire logic                         rsp_last_i
);

  // A result stays offered until taken.
  `MGT_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped")

  // One item at a time: no new item right after one is taken.
  `MGT_ASSERT(a_one_item, cmd_valid_i && cmd_ready_i |=> !cmd_ready_i, "item overlap")

  // An error result is always marked last.
  `MGT_ASSERT(a_err_last, rsp_valid_i && rsp_status_i != mgt_pkg::ST_OK |-> rsp_last_i, "error not last")

  // A nonzero match count comes only with a hit.
  `MGT_ASSERT(a_cnt_hit, rsp_valid_i && rsp_match_count_i != '0 |-> rsp_hit_i, "count without hit")

endmodule

bind mac_group_membership_table_core mgt_checker u_mgt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cmd_valid_i       (cmd_i.valid),
  .cmd_ready_i       (cmd_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_match_count_i (rsp_o.match_count),
  .rsp_last_i        (rsp_o.last)
);

`default_nettype wire
